@@ rtl/core/sit_pkg.sv @@
// Shared types, widths and helpers for the segment intersection test unit.
// Depends on nothing; every other file in rtl/core imports it.
package sit_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SQ_W       = 2 * COORD_BITS + 1;

	typedef enum logic [2:0] {
		ORIENT_CCW    = 3'd0,
		ORIENT_CW     = 3'd1,
		ORIENT_BEHIND = 3'd2,
		ORIENT_BEYOND = 3'd3,
		ORIENT_ON     = 3'd4
	} orient_code_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_start_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_end_y;
	} req_t;

	typedef struct packed {
		logic         segments_meet;
		orient_code_t orient_second_start;
		orient_code_t orient_second_end;
		orient_code_t orient_first_start;
		orient_code_t orient_first_end;
	} res_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] x;
		logic signed [DIFF_W-1:0] y;
	} vec_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] cross_a;
		logic signed [PROD_W-1:0] cross_b;
		logic signed [PROD_W-1:0] dot_x;
		logic signed [PROD_W-1:0] dot_y;
		logic        [SQ_W-1:0]   len_ux;
		logic        [SQ_W-1:0]   len_uy;
		logic        [SQ_W-1:0]   len_vx;
		logic        [SQ_W-1:0]   len_vy;
	} orient_prod_t;

	function automatic logic code_pos(orient_code_t c);
		return (c == ORIENT_CCW) || (c == ORIENT_BEHIND);
	endfunction

	function automatic logic code_neg(orient_code_t c);
		return (c == ORIENT_CW) || (c == ORIENT_BEYOND);
	endfunction

	// A pair of codes blocks a meeting when both lie strictly on the same side.
	function automatic logic pair_blocks(orient_code_t a, orient_code_t b);
		return (code_pos(a) && code_pos(b)) || (code_neg(a) && code_neg(b));
	endfunction

endpackage

@@ rtl/core/sit_orient_mult.sv @@
// Products for one orientation test: cross terms, dot terms and squared lengths.
// Depends on sit_pkg.
module sit_orient_mult
	import sit_pkg::*;
(
	input  vec_t         u,
	input  vec_t         v,
	output orient_prod_t prod
);

	logic signed [PROD_W-1:0] sq_ux, sq_uy, sq_vx, sq_vy;

	always_comb begin
		sq_ux = u.x * u.x;
		sq_uy = u.y * u.y;
		sq_vx = v.x * v.x;
		sq_vy = v.y * v.y;
		prod.cross_a = u.x * v.y;
		prod.cross_b = u.y * v.x;
		prod.dot_x   = u.x * v.x;
		prod.dot_y   = u.y * v.y;
		prod.len_ux  = sq_ux[SQ_W-1:0];
		prod.len_uy  = sq_uy[SQ_W-1:0];
		prod.len_vx  = sq_vx[SQ_W-1:0];
		prod.len_vy  = sq_vy[SQ_W-1:0];
	end

endmodule

@@ rtl/core/sit_orient_classify.sv @@
// Turns the registered products of one orientation test into its code.
// Depends on sit_pkg.
module sit_orient_classify
	import sit_pkg::*;
(
	input  orient_prod_t prod,
	output orient_code_t code
);

	logic signed [PROD_W:0] dot_sum;
	logic        [SQ_W:0]   len_u, len_v;

	always_comb begin
		dot_sum = (PROD_W+1)'(prod.dot_x) + (PROD_W+1)'(prod.dot_y);
		len_u   = {1'b0, prod.len_ux} + {1'b0, prod.len_uy};
		len_v   = {1'b0, prod.len_vx} + {1'b0, prod.len_vy};
		if (prod.cross_a > prod.cross_b) begin
			code = ORIENT_CCW;
		end else if (prod.cross_a < prod.cross_b) begin
			code = ORIENT_CW;
		end else if (dot_sum < 0) begin
			code = ORIENT_BEHIND;
		end else if (len_u < len_v) begin
			code = ORIENT_BEYOND;
		end else begin
			code = ORIENT_ON;
		end
	end

endmodule

@@ rtl/core/segment_intersection_test_unit.sv @@
// Segment intersection test: four orientation codes and a meet flag per request.
// The result passes through the four register stages of difference, multiply, compare and result
// register. One request per cycle is taken while no stalled result backs up to the request side.
// A stalled result holds the occupied stages in place while empty stages still fill.
// Reset clears all valid bits; payload registers are not reset.
module segment_intersection_test_unit
	import sit_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic         en_s1, en_s2, en_s3, en_s4;
	logic         v_s1, v_s2, v_s3, v_s4;
	vec_t         u_p_s1, u_q_s1, c_q0_s1, c_q1_s1, c_p0_s1, c_p1_s1;
	vec_t         base [4];
	vec_t         pt [4];
	orient_prod_t prod_c [4];
	orient_prod_t prod_s2 [4];
	orient_code_t code_c [4];
	orient_code_t code_s3 [4];
	res_t         res_s4;

	assign en_s4     = !v_s4 || res_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req_ready = en_s1;
	assign res_valid = v_s4;
	assign res       = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			u_p_s1.x  <= DIFF_W'(req.first_end_x) - DIFF_W'(req.first_start_x);
			u_p_s1.y  <= DIFF_W'(req.first_end_y) - DIFF_W'(req.first_start_y);
			u_q_s1.x  <= DIFF_W'(req.second_end_x) - DIFF_W'(req.second_start_x);
			u_q_s1.y  <= DIFF_W'(req.second_end_y) - DIFF_W'(req.second_start_y);
			c_q0_s1.x <= DIFF_W'(req.second_start_x) - DIFF_W'(req.first_start_x);
			c_q0_s1.y <= DIFF_W'(req.second_start_y) - DIFF_W'(req.first_start_y);
			c_q1_s1.x <= DIFF_W'(req.second_end_x) - DIFF_W'(req.first_start_x);
			c_q1_s1.y <= DIFF_W'(req.second_end_y) - DIFF_W'(req.first_start_y);
			c_p0_s1.x <= DIFF_W'(req.first_start_x) - DIFF_W'(req.second_start_x);
			c_p0_s1.y <= DIFF_W'(req.first_start_y) - DIFF_W'(req.second_start_y);
			c_p1_s1.x <= DIFF_W'(req.first_end_x) - DIFF_W'(req.second_start_x);
			c_p1_s1.y <= DIFF_W'(req.first_end_y) - DIFF_W'(req.second_start_y);
		end
	end

	assign base[0] = u_p_s1;
	assign base[1] = u_p_s1;
	assign base[2] = u_q_s1;
	assign base[3] = u_q_s1;
	assign pt[0]   = c_q0_s1;
	assign pt[1]   = c_q1_s1;
	assign pt[2]   = c_p0_s1;
	assign pt[3]   = c_p1_s1;

	for (genvar i = 0; i < 4; i++) begin : g_test
		sit_orient_mult u_mult (
			.u    (base[i]),
			.v    (pt[i]),
			.prod (prod_c[i])
		);

		sit_orient_classify u_classify (
			.prod (prod_s2[i]),
			.code (code_c[i])
		);

		always_ff @(posedge clk) begin
			if (en_s2 && v_s1) prod_s2[i] <= prod_c[i];
			if (en_s3 && v_s2) code_s3[i] <= code_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			res_s4.orient_second_start <= code_s3[0];
			res_s4.orient_second_end   <= code_s3[1];
			res_s4.orient_first_start  <= code_s3[2];
			res_s4.orient_first_end    <= code_s3[3];
			res_s4.segments_meet       <= !pair_blocks(code_s3[0], code_s3[1]) &&
				!pair_blocks(code_s3[2], code_s3[3]);
		end
	end

	a_same_side_no_meet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.orient_second_start == ORIENT_CCW &&
		res.orient_second_end == ORIENT_CCW |-> !res.segments_meet)
		else $error("Both second endpoints counterclockwise yet meet reported.");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Stalled result changed or dropped before acceptance.");

	a_codes_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.orient_second_start <= ORIENT_ON &&
		res.orient_second_end <= ORIENT_ON && res.orient_first_start <= ORIENT_ON &&
		res.orient_first_end <= ORIENT_ON)
		else $error("Orientation code out of range.");

endmodule

@@ verif/tb_segment_intersection_test_unit.sv @@
// Self-checking testbench for segment_intersection_test_unit: directed and random segment
// pairs go through the request channel and every result is checked against a local predictor.
// Depends on sit_pkg and the segment_intersection_test_unit RTL.
`timescale 1ns / 100ps

module tb_segment_intersection_test_unit;
	import sit_pkg::*;

	localparam int RANDOM_PAIRS = 700;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;

	class verdict_board;
		res_t expected_verdicts[$];
		int   failures = 0;

		function orient_code_t classify_point(longint ax, longint ay, longint bx, longint by,
				longint cx, longint cy);
			longint ux = bx - ax;
			longint uy = by - ay;
			longint vx = cx - ax;
			longint vy = cy - ay;
			if (ux * vy > uy * vx) return ORIENT_CCW;
			if (ux * vy < uy * vx) return ORIENT_CW;
			if (ux * vx + uy * vy < 0) return ORIENT_BEHIND;
			if (ux * ux + uy * uy < vx * vx + vy * vy) return ORIENT_BEYOND;
			return ORIENT_ON;
		endfunction

		function int side_weight(orient_code_t c);
			case (c)
				ORIENT_CCW:    return 1;
				ORIENT_CW:     return -1;
				ORIENT_BEHIND: return 2;
				ORIENT_BEYOND: return -2;
				default:       return 0;
			endcase
		endfunction

		function res_t predict_verdict(req_t r);
			longint p0x = r.first_start_x;
			longint p0y = r.first_start_y;
			longint p1x = r.first_end_x;
			longint p1y = r.first_end_y;
			longint q0x = r.second_start_x;
			longint q0y = r.second_start_y;
			longint q1x = r.second_end_x;
			longint q1y = r.second_end_y;
			res_t v;
			v.orient_second_start = classify_point(p0x, p0y, p1x, p1y, q0x, q0y);
			v.orient_second_end   = classify_point(p0x, p0y, p1x, p1y, q1x, q1y);
			v.orient_first_start  = classify_point(q0x, q0y, q1x, q1y, p0x, p0y);
			v.orient_first_end    = classify_point(q0x, q0y, q1x, q1y, p1x, p1y);
			v.segments_meet =
				(side_weight(v.orient_second_start) * side_weight(v.orient_second_end) <= 0) &&
				(side_weight(v.orient_first_start) * side_weight(v.orient_first_end) <= 0);
			return v;
		endfunction

		function void note_request(req_t r);
			expected_verdicts = {expected_verdicts, predict_verdict(r)};
		endfunction

		function void compare_field(string name, logic [2:0] want, logic [2:0] got);
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t result %p arrived with no request outstanding", $realtime, got);
				return;
			end
			want = expected_verdicts.pop_front();
			compare_field("segments_meet", {2'b00, want.segments_meet}, {2'b00, got.segments_meet});
			compare_field("orient_second_start", want.orient_second_start, got.orient_second_start);
			compare_field("orient_second_end", want.orient_second_end, got.orient_second_end);
			compare_field("orient_first_start", want.orient_first_start, got.orient_first_start);
			compare_field("orient_first_end", want.orient_first_end, got.orient_first_end);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	verdict_board board = new;
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int directed_pts[22][8] = '{
		'{0, 0, 4, 4, 0, 4, 4, 0},
		'{0, 0, 4, 0, 0, 1, 4, 1},
		'{0, 0, 4, 0, 2, 0, 6, 0},
		'{0, 0, 2, 0, 3, 0, 5, 0},
		'{0, 0, 2, 0, -5, 0, -3, 0},
		'{0, 0, 2, 0, -1, 0, 3, 0},
		'{0, 0, 2, 2, 2, 2, 4, 0},
		'{0, 0, 4, 0, 2, 0, 2, 3},
		'{0, 0, 4, 0, 2, 1, 2, 3},
		'{1, 1, 1, 1, 3, 3, 5, 5},
		'{1, 1, 1, 1, 1, 1, 5, 5},
		'{7, -7, 7, -7, 7, -7, 7, -7},
		'{0, 0, 0, 0, 1, 1, 1, 1},
		'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
		'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
		'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
		'{-32768, 0, 32767, 0, 32767, 0, -32768, 0},
		'{32767, -32768, -32768, -32768, 0, 32767, 0, -32768},
		'{0, 0, 4, 0, 1, -1, 3, -3},
		'{0, 0, 1, 0, 5, -1, 5, 1},
		'{0, 0, 2, 0, -2, 0, 0, 0},
		'{-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768}
	};

	segment_intersection_test_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	function automatic bit side_idles();
		return !steady && ($urandom_range(0, 99) < 27);
	endfunction

	function automatic int wide_coord();
		case ($urandom_range(0, 7))
			0:       return -32768;
			1:       return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int grid_coord(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic req_t make_pair(input int pt[8]);
		req_t r;
		r.first_start_x  = COORD_BITS'(pt[0]);
		r.first_start_y  = COORD_BITS'(pt[1]);
		r.first_end_x    = COORD_BITS'(pt[2]);
		r.first_end_y    = COORD_BITS'(pt[3]);
		r.second_start_x = COORD_BITS'(pt[4]);
		r.second_start_y = COORD_BITS'(pt[5]);
		r.second_end_x   = COORD_BITS'(pt[6]);
		r.second_end_y   = COORD_BITS'(pt[7]);
		return r;
	endfunction

	function automatic req_t random_pair();
		int pt[8];
		int kind, bx, by, dx, dy, k, j;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			foreach (pt[i]) pt[i] = wide_coord();
		end else if (kind < 55) begin
			foreach (pt[i]) pt[i] = grid_coord(4);
		end else if (kind < 75) begin
			bx = grid_coord(1000);
			by = grid_coord(1000);
			dx = grid_coord(3);
			dy = grid_coord(3);
			for (int i = 0; i < 4; i++) begin
				k = grid_coord(4);
				pt[2 * i]     = bx + k * dx;
				pt[2 * i + 1] = by + k * dy;
			end
		end else if (kind < 90) begin
			foreach (pt[i]) pt[i] = grid_coord(20);
			j = $urandom_range(0, 1);
			k = 4 + 2 * $urandom_range(0, 1);
			pt[k]     = pt[2 * j];
			pt[k + 1] = pt[2 * j + 1];
		end else begin
			foreach (pt[i]) pt[i] = grid_coord(3);
			pt[2] = pt[0];
			pt[3] = pt[1];
			if ($urandom_range(0, 1)) begin
				pt[6] = pt[4];
				pt[7] = pt[5];
			end
			if ($urandom_range(0, 3) == 0) begin
				pt[4] = pt[0];
				pt[5] = pt[1];
			end
		end
		return make_pair(pt);
	endfunction

	task automatic send_request(input req_t r);
		if (side_idles()) begin
			req_valid <= 1'b0;
			do @(posedge clk); while (side_idles());
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		board.note_request(r);
	endtask

	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) board.check_result(res);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= !side_idles();
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_pts[i]) send_request(make_pair(directed_pts[i]));
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			steady = (n >= 200 && n < 360);
			if (n == 240) hold_request = 1'b1;
			send_request(random_pair());
		end
		steady = 1'b0;
		req_valid <= 1'b0;
		while (board.expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.failures == 0 && board.expected_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
